// ----- hdl/flspq_pkg.sv -----
// ----------------------------------------------------------------------------
// flspq_pkg
// Types and constants shared by the four-level stable priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package flspq_pkg;

    localparam int TAG_W = 16;
    localparam int LVL_W = 3;

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_CALL = 1'b1;

    localparam logic [LVL_W-1:0] LVL_CRITICAL = 3'd4;
    localparam logic [LVL_W-1:0] LVL_SERIOUS  = 3'd3;

    localparam logic [1:0] ROOM_EMERGENCY    = 2'd0;
    localparam logic [1:0] ROOM_EXAMINATION  = 2'd1;
    localparam logic [1:0] ROOM_CONSULTATION = 2'd2;

    localparam logic [1:0] ST_ADDED  = 2'd0;
    localparam logic [1:0] ST_SERVED = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic             action;
        logic [LVL_W-1:0] severity;
        logic [TAG_W-1:0] patient_tag;
    } in_word_t;

    typedef struct packed {
        logic [TAG_W-1:0] served_tag;
        logic [1:0]       room_class;
        logic [1:0]       status;
    } out_word_t;

    // broadcast to every cell
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [LVL_W-1:0] level;
    } cell_ctrl_t;

    function automatic logic [1:0] room_of(input logic [LVL_W-1:0] level);
        logic [1:0] room;
        case (level)
            LVL_CRITICAL: room = ROOM_EMERGENCY;
            LVL_SERIOUS:  room = ROOM_EXAMINATION;
            default:      room = ROOM_CONSULTATION;
        endcase
        return room;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/flspq_cell.sv -----
// ----------------------------------------------------------------------------
// flspq_cell
// One slot of the sorted chain: holds a tag and level, keeps its entry,
// takes the new entry or takes a neighbor's entry each cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module flspq_cell #(
    parameter int TAG_BITS = 16
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire  flspq_pkg::cell_ctrl_t        ctrl_i,
    input  wire  [TAG_BITS-1:0]                new_tag_i,
    input  wire                                left_keep_i,
    input  wire                                left_valid_i,
    input  wire  [flspq_pkg::LVL_W-1:0]        left_level_i,
    input  wire  [TAG_BITS-1:0]                left_tag_i,
    input  wire                                right_valid_i,
    input  wire  [flspq_pkg::LVL_W-1:0]        right_level_i,
    input  wire  [TAG_BITS-1:0]                right_tag_i,
    output logic                               keep_o,
    output logic                               valid_o,
    output logic [flspq_pkg::LVL_W-1:0]        level_o,
    output logic [TAG_BITS-1:0]                tag_o
);

    logic                        valid_reg, valid_next;
    logic [flspq_pkg::LVL_W-1:0] level_reg, level_next;
    logic [TAG_BITS-1:0]         tag_reg, tag_next;
    logic                        keep;

    // entry stays put on insert when it is at least as urgent
    assign keep = valid_reg && (level_reg >= ctrl_i.level);

    always_comb begin
        valid_next = valid_reg;
        level_next = level_reg;
        tag_next   = tag_reg;
        if (ctrl_i.ins && !keep) begin
            if (left_keep_i) begin
                valid_next = 1'b1;
                level_next = ctrl_i.level;
                tag_next   = new_tag_i;
            end else begin
                valid_next = left_valid_i;
                level_next = left_level_i;
                tag_next   = left_tag_i;
            end
        end else if (ctrl_i.rem) begin
            valid_next = right_valid_i;
            level_next = right_level_i;
            tag_next   = right_tag_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        level_reg <= level_next;
        tag_reg   <= tag_next;
    end

    assign keep_o  = keep;
    assign valid_o = valid_reg;
    assign level_o = level_reg;
    assign tag_o   = tag_reg;

endmodule

`default_nettype wire

// ----- hdl/four_level_stable_priority_queue.sv -----
// ----------------------------------------------------------------------------
// four_level_stable_priority_queue
// Bounded priority queue with stable ordering inside each severity level.
//
// Input channel s_valid/s_ready/s_word: action 0 adds patient_tag at its
// severity behind all entries of equal or higher severity; action 1 calls
// the head entry. Every input word yields exactly one result word on
// m_valid/m_ready/m_word: status added, served (with served_tag and
// room_class), refused because full, or empty.
// Storage is a chain of CAPACITY cells sorted head first; an insert or a
// removal updates every cell in the same cycle from its neighbors.
// The result is registered; m_valid rises in the cycle after acceptance.
// Throughput is one word per cycle; the single output register is the only
// limit, so s_ready drops while a result is waiting and m_ready is low.
// Reset (aresetn low, synchronous) empties the queue and the output
// register at once; no clearing sweep is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module four_level_stable_priority_queue #(
    parameter int CAPACITY = 64,
    parameter int TAG_BITS = 16
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire flspq_pkg::in_word_t s_word,
    output logic                  m_valid,
    input  wire                   m_ready,
    output flspq_pkg::out_word_t  m_word
);

    // index 0 is the left boundary, CAPACITY+1 the right boundary
    logic [CAPACITY+1:0]         c_valid;
    logic [CAPACITY:0]           c_keep;
    logic [flspq_pkg::LVL_W-1:0] c_level [0:CAPACITY+1];
    logic [TAG_BITS-1:0]         c_tag   [0:CAPACITY+1];

    flspq_pkg::cell_ctrl_t ctrl;
    flspq_pkg::out_word_t  word_reg, word_next;
    logic                  m_valid_reg;
    logic                  accept;
    logic                  full;
    logic                  empty;
    logic [TAG_BITS-1:0]   new_tag;

    assign c_valid[0]          = 1'b0;
    assign c_keep[0]           = 1'b1;
    assign c_level[0]          = '0;
    assign c_tag[0]            = '0;
    assign c_valid[CAPACITY+1] = 1'b0;
    assign c_level[CAPACITY+1] = '0;
    assign c_tag[CAPACITY+1]   = '0;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = c_valid[CAPACITY];
    assign empty   = !c_valid[1];
    assign new_tag = TAG_BITS'(s_word.patient_tag);

    always_comb begin
        ctrl.ins   = accept && (s_word.action == flspq_pkg::ACT_ADD) && !full;
        ctrl.rem   = accept && (s_word.action == flspq_pkg::ACT_CALL) && !empty;
        ctrl.level = s_word.severity;
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        flspq_cell #(
            .TAG_BITS (TAG_BITS)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .ctrl_i        (ctrl),
            .new_tag_i     (new_tag),
            .left_keep_i   (c_keep[i]),
            .left_valid_i  (c_valid[i]),
            .left_level_i  (c_level[i]),
            .left_tag_i    (c_tag[i]),
            .right_valid_i (c_valid[i+2]),
            .right_level_i (c_level[i+2]),
            .right_tag_i   (c_tag[i+2]),
            .keep_o        (c_keep[i+1]),
            .valid_o       (c_valid[i+1]),
            .level_o       (c_level[i+1]),
            .tag_o         (c_tag[i+1])
        );
    end

    always_comb begin
        word_next = '0;
        if (s_word.action == flspq_pkg::ACT_ADD) begin
            word_next.status = full ? flspq_pkg::ST_FULL : flspq_pkg::ST_ADDED;
        end else if (empty) begin
            word_next.status = flspq_pkg::ST_EMPTY;
        end else begin
            word_next.served_tag = flspq_pkg::TAG_W'(c_tag[1]);
            word_next.room_class = flspq_pkg::room_of(c_level[1]);
            word_next.status     = flspq_pkg::ST_SERVED;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            word_reg <= word_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = word_reg;

`ifndef ASSERT_OFF
    // occupied cells form an unbroken run from the head
    a_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        ((c_valid[CAPACITY:1] & (c_valid[CAPACITY:1] + 1'b1)) == '0))
        else $error("occupied cells not contiguous");

    a_add_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.ins |=> $countones(c_valid) == $past($countones(c_valid)) + 1)
        else $error("insert did not grow the queue by one");

    a_call_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.rem |=> $countones(c_valid) + 1 == $past($countones(c_valid)))
        else $error("call did not shrink the queue by one");

    a_full_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (word_reg.status == flspq_pkg::ST_FULL)) |-> full)
        else $error("refused add reported while queue not full");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb_four_level_stable_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_four_level_stable_priority_queue
// Self-checking bench for the four-level stable priority queue.
//
// A short scripted sequence covers an empty call, every severity including
// the out-of-range codes, stable order within a level, a full store and a
// refused add, and a full drain. Random phases follow, some heavy on adds and
// some heavy on calls, so the queue swings between empty and full. Every
// accepted word goes through a local triage model, and each result word is
// compared field by field with the oldest pending expectation. Both sides
// idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------

module tb_four_level_stable_priority_queue;

    localparam int CAPACITY   = 64;
    localparam int TAG_BITS   = 16;
    localparam int RAND_WORDS = 1800;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_AT    = 300;
    localparam int HOLD_LEN   = 400;

    localparam flspq_pkg::out_word_t NO_CHECK = '0;
    localparam flspq_pkg::out_word_t ADDED_W  =
        {16'h0000, flspq_pkg::ROOM_EMERGENCY, flspq_pkg::ST_ADDED};
    localparam flspq_pkg::out_word_t FULL_W   =
        {16'h0000, flspq_pkg::ROOM_EMERGENCY, flspq_pkg::ST_FULL};
    localparam flspq_pkg::out_word_t EMPTY_W  =
        {16'h0000, flspq_pkg::ROOM_EMERGENCY, flspq_pkg::ST_EMPTY};

    typedef struct {
        flspq_pkg::in_word_t  word;
        int unsigned          reps;
        bit                   typed;
        flspq_pkg::out_word_t want;
    } script_row_t;

    localparam int N_ROWS = 18;

    // adds in a repeated row get tag + repeat index
    script_row_t script [N_ROWS] = '{
        '{{flspq_pkg::ACT_CALL, 3'd0, 16'h0000}, 1,  1'b1, EMPTY_W},
        '{{flspq_pkg::ACT_ADD,  3'd4, 16'hFFFF}, 1,  1'b1, ADDED_W},
        '{{flspq_pkg::ACT_ADD,  3'd1, 16'h0000}, 1,  1'b1, ADDED_W},
        '{{flspq_pkg::ACT_ADD,  3'd4, 16'h0001}, 1,  1'b1, ADDED_W},
        '{{flspq_pkg::ACT_ADD,  3'd3, 16'h00AA}, 1,  1'b1, ADDED_W},
        '{{flspq_pkg::ACT_ADD,  3'd2, 16'h0055}, 1,  1'b1, ADDED_W},
        '{{flspq_pkg::ACT_ADD,  3'd0, 16'h7FFF}, 1,  1'b1, ADDED_W},
        '{{flspq_pkg::ACT_ADD,  3'd7, 16'h8000}, 1,  1'b1, ADDED_W},
        '{{flspq_pkg::ACT_ADD,  3'd5, 16'h1111}, 1,  1'b1, ADDED_W},
        '{{flspq_pkg::ACT_ADD,  3'd6, 16'h2222}, 1,  1'b1, ADDED_W},
        '{{flspq_pkg::ACT_CALL, 3'd0, 16'h0000}, 9,  1'b0, NO_CHECK},
        '{{flspq_pkg::ACT_CALL, 3'd7, 16'hFFFF}, 1,  1'b1, EMPTY_W},
        '{{flspq_pkg::ACT_ADD,  3'd2, 16'h4000}, 64, 1'b1, ADDED_W},
        '{{flspq_pkg::ACT_ADD,  3'd3, 16'hBEEF}, 1,  1'b1, FULL_W},
        '{{flspq_pkg::ACT_CALL, 3'd7, 16'hFFFF}, 1,  1'b0, NO_CHECK},
        '{{flspq_pkg::ACT_ADD,  3'd4, 16'hCAFE}, 1,  1'b1, ADDED_W},
        '{{flspq_pkg::ACT_CALL, 3'd0, 16'h0000}, 64, 1'b0, NO_CHECK},
        '{{flspq_pkg::ACT_CALL, 3'd0, 16'h0000}, 1,  1'b1, EMPTY_W}
    };

    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    flspq_pkg::in_word_t  s_word  = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    flspq_pkg::out_word_t m_word;

    // triage model state
    logic [flspq_pkg::TAG_W-1:0] ward_tags   [CAPACITY];
    logic [flspq_pkg::LVL_W-1:0] ward_levels [CAPACITY];
    int unsigned                 ward_count = 0;

    flspq_pkg::out_word_t due_results [$];
    int unsigned words_in       = 0;
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles    = 0;
    bit          rx_calm        = 1'b0;
    bit          hold_done      = 1'b0;

    four_level_stable_priority_queue #(
        .CAPACITY (CAPACITY),
        .TAG_BITS (TAG_BITS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic flspq_pkg::out_word_t triage(input flspq_pkg::in_word_t w);
        flspq_pkg::out_word_t r;
        int unsigned          pos;
        r = '0;
        if (w.action == flspq_pkg::ACT_ADD) begin
            if (ward_count >= CAPACITY) begin
                r.status = flspq_pkg::ST_FULL;
            end else begin
                pos = 0;
                while (pos < ward_count && ward_levels[pos] >= w.severity) pos++;
                for (int unsigned i = ward_count; i > pos; i--) begin
                    ward_tags[i]   = ward_tags[i-1];
                    ward_levels[i] = ward_levels[i-1];
                end
                ward_tags[pos]   = w.patient_tag;
                ward_levels[pos] = w.severity;
                ward_count++;
                r.status = flspq_pkg::ST_ADDED;
            end
        end else if (ward_count == 0) begin
            r.status = flspq_pkg::ST_EMPTY;
        end else begin
            r.served_tag = ward_tags[0];
            case (ward_levels[0])
                flspq_pkg::LVL_CRITICAL: r.room_class = flspq_pkg::ROOM_EMERGENCY;
                flspq_pkg::LVL_SERIOUS:  r.room_class = flspq_pkg::ROOM_EXAMINATION;
                default:                 r.room_class = flspq_pkg::ROOM_CONSULTATION;
            endcase
            r.status = flspq_pkg::ST_SERVED;
            for (int unsigned i = 1; i < ward_count; i++) begin
                ward_tags[i-1]   = ward_tags[i];
                ward_levels[i-1] = ward_levels[i];
            end
            ward_count--;
        end
        return r;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int unsigned pause_len(input bit calm);
        int unsigned roll;
        roll = $urandom_range(99);
        if (calm || roll < 55) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic push_word(input flspq_pkg::in_word_t w, input bit typed,
                             input flspq_pkg::out_word_t want, input int unsigned gap);
        flspq_pkg::out_word_t predicted;
        s_word  <= w;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_in++;
        predicted = triage(w);
        due_results.push_back(typed ? want : predicted);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // sender
    initial begin
        flspq_pkg::in_word_t w;
        int unsigned         sent;
        int unsigned         phase_len;
        int unsigned         add_pct;
        bit                  tx_calm;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < N_ROWS; r++) begin
            for (int unsigned k = 0; k < script[r].reps; k++) begin
                w = script[r].word;
                if (w.action == flspq_pkg::ACT_ADD) begin
                    w.patient_tag = w.patient_tag + flspq_pkg::TAG_W'(k);
                end
                push_word(w, script[r].typed, script[r].want, pause_len(1'b0));
            end
        end

        sent = 0;
        while (sent < RAND_WORDS) begin
            phase_len = $urandom_range(20, 150);
            case ($urandom_range(2))
                0:       add_pct = 90;
                1:       add_pct = 50;
                default: add_pct = 15;
            endcase
            tx_calm = ($urandom_range(3) == 0);
            for (int unsigned k = 0; k < phase_len; k++) begin
                w.action      = ($urandom_range(99) < add_pct) ? flspq_pkg::ACT_ADD
                                                               : flspq_pkg::ACT_CALL;
                w.severity    = ($urandom_range(9) < 8)
                                ? flspq_pkg::LVL_W'($urandom_range(1, 4))
                                : flspq_pkg::LVL_W'($urandom_range(7));
                w.patient_tag = flspq_pkg::TAG_W'($urandom);
                push_word(w, 1'b0, NO_CHECK, pause_len(tx_calm));
                sent++;
            end
        end
        s_valid <= 1'b0;

        while (due_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb_four_level_stable_priority_queue: done, clean");
        end else begin
            $display("tb_four_level_stable_priority_queue: done, errors");
        end
        $finish;
    end

    // receiver
    initial begin
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (!hold_done && words_in >= HOLD_AT) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            if ($urandom_range(59) == 0) rx_calm = ~rx_calm;
            if (pause_len(rx_calm) != 0) begin
                m_ready <= 1'b0;
                repeat (pause_len(1'b0) + 1) @(posedge aclk);
            end
        end
    end

    // result check
    always @(posedge aclk) begin
        flspq_pkg::out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                $error("result word with nothing pending: %h", m_word);
                mismatch_count++;
            end else begin
                want = due_results.pop_front();
                if (m_word.served_tag !== want.served_tag) begin
                    $error("served_tag: expected %h, got %h", want.served_tag,
                           m_word.served_tag);
                    mismatch_count++;
                end
                if (m_word.room_class !== want.room_class) begin
                    $error("room_class: expected %0d, got %0d", want.room_class,
                           m_word.room_class);
                    mismatch_count++;
                end
                if (m_word.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_word.status);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_four_level_stable_priority_queue: done, errors");
            $finish;
        end
    end

endmodule
